// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL files that check themselves.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- sv/pbd_pkg.sv -----
// Types and constants of the Poisson-binomial count distribution block.
package pbd_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int PROB_W        = FRACTION_BITS + 1;
	localparam int ACC_W         = 2 * PROB_W;
	localparam int MAX_EVENTS    = 63;
	localparam int STORE_DEPTH   = 64;
	localparam int COUNT_W       = 6;

	localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(1) << FRACTION_BITS;
	localparam logic [ACC_W-1:0]  PROB_HALF = ACC_W'(1) << (FRACTION_BITS - 1);

	// One incoming request.
	typedef struct packed {
		logic [PROB_W-1:0] event_probability;
		logic              final_event;
	} in_t;

	// One emitted result.
	typedef struct packed {
		logic [COUNT_W-1:0] event_count;
		logic [PROB_W-1:0]  count_probability;
		logic               last_result;
		logic               overflow;
	} out_t;

	// What every cell of the row does this cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_UPDATE,
		CELL_SHIFT,
		CELL_CLEAR
	} cell_op_t;

	// Control broadcast to the row of cells.
	typedef struct packed {
		cell_op_t          op;
		logic [PROB_W-1:0] p;
		logic [PROB_W-1:0] q;
	} cell_ctl_t;

endpackage

// ----- sv/pbd_cell.sv -----
// One cell of the count row: holds the probability of one event count.
module pbd_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  pbd_pkg::cell_ctl_t        ctl,
	input  logic [pbd_pkg::PROB_W-1:0] rst_val,
	input  logic [pbd_pkg::PROB_W-1:0] prev_d,
	input  logic [pbd_pkg::PROB_W-1:0] next_d,
	output logic [pbd_pkg::PROB_W-1:0] d
);
	import pbd_pkg::*;

	logic [PROB_W-1:0] d_q;
	logic [ACC_W-1:0]  acc;

	// d[k]*(1-p) + d[k-1]*p, rounded half up
	assign acc = ACC_W'(d_q) * ACC_W'(ctl.q) + ACC_W'(prev_d) * ACC_W'(ctl.p) + PROB_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= rst_val;
		end else begin
			case (ctl.op)
				CELL_UPDATE: d_q <= acc[FRACTION_BITS +: PROB_W];
				CELL_SHIFT:  d_q <= next_d;
				CELL_CLEAR:  d_q <= rst_val;
				default:     d_q <= d_q;
			endcase
		end
	end

	assign d = d_q;

endmodule

// ----- sv/poisson_binomial_distribution.sv -----
// Poisson-binomial count distribution: top level with control and the row of cells.
//
//  channel   direction  handshake              payload
//  request   in         start && !busy         event_probability, final_event
//  result    out        strobe (one cycle)     event_count, count_probability,
//                                              last_result, overflow
//
// Each accepted request updates all 64 cells in parallel, unless 63 events are already taken;
// then it sets overflow instead. A final request is then followed by n+1 results (n = events taken),
// one result per cycle shifted out of cell zero; busy is high while they are emitted.
// Each result is registered and strobes in the cycle after its emit cycle.
// The last emit cycle reloads the row to its reset values.
// Reset sets cell zero to one and the rest to zero; results cannot be stalled.
module poisson_binomial_distribution (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  pbd_pkg::in_t request,
	output logic         busy,
	output logic         strobe,
	output pbd_pkg::out_t result
);
	import pbd_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] events_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               ovf_q;
	logic               strobe_q;
	out_t               result_q;

	logic               accept;
	logic               take;
	logic               emit_last;
	logic [PROB_W-1:0]  p_sat;
	cell_ctl_t          ctl;
	logic [PROB_W-1:0]  d_arr    [STORE_DEPTH];
	logic [PROB_W-1:0]  prev_arr [STORE_DEPTH];
	logic [PROB_W-1:0]  next_arr [STORE_DEPTH];

	assign busy      = (state_q == ST_EMIT);
	assign accept    = start && !busy;
	assign take      = (events_q < COUNT_W'(MAX_EVENTS));
	assign emit_last = (cnt_q == events_q);

	// saturate p at one
	assign p_sat = (request.event_probability > PROB_ONE) ? PROB_ONE : request.event_probability;

	// row control
	always_comb begin
		ctl.p  = p_sat;
		ctl.q  = PROB_ONE - p_sat;
		ctl.op = CELL_HOLD;
		if (state_q == ST_EMIT) begin
			ctl.op = emit_last ? CELL_CLEAR : CELL_SHIFT;
		end else if (accept && take) begin
			ctl.op = CELL_UPDATE;
		end
	end

	// neighbor links, zero past both ends
	for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_link
		if (g == 0) begin : g_prev
			assign prev_arr[g] = '0;
		end else begin : g_prev
			assign prev_arr[g] = d_arr[g-1];
		end
		if (g == STORE_DEPTH - 1) begin : g_next
			assign next_arr[g] = '0;
		end else begin : g_next
			assign next_arr[g] = d_arr[g+1];
		end
	end

	// row of cells
	for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
		pbd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.rst_val ((g == 0) ? PROB_ONE : '0),
			.prev_d  (prev_arr[g]),
			.next_d  (next_arr[g]),
			.d       (d_arr[g])
		);
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			events_q <= '0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					strobe_q <= 1'b0;
					if (accept) begin
						if (take) begin
							events_q <= events_q + COUNT_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (request.final_event) begin
							cnt_q   <= '0;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					strobe_q                   <= 1'b1;
					result_q.event_count       <= cnt_q;
					result_q.count_probability <= d_arr[0];
					result_q.last_result       <= emit_last;
					result_q.overflow          <= ovf_q;
					if (emit_last) begin
						events_q <= '0;
						ovf_q    <= 1'b0;
						state_q  <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + COUNT_W'(1);
					end
				end
				default: begin
					strobe_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	`include "assert_macros.svh"

	`ASSERT_CLK(a_strobe_after_emit, strobe |-> $past(busy), "result without an emit cycle")
	`ASSERT_CLK(a_last_frees, (strobe && result.last_result) |-> !busy, "busy after last result")
	`ASSERT_CLK(a_burst_contiguous, (strobe && !result.last_result) |=> strobe, "gap in results")
	`ASSERT_CLK(a_final_emits, (accept && request.final_event) |=> busy, "final request not emitted")
	`ASSERT_NEVER(a_events_bound, events_q > COUNT_W'(MAX_EVENTS), "event count past limit")

endmodule
